// File: sv/i420_test_pattern_generator_assert.svh
// Assertion macros shared by the I420 test pattern generator RTL
`ifndef I420_TEST_PATTERN_GENERATOR_ASSERT_SVH
`define I420_TEST_PATTERN_GENERATOR_ASSERT_SVH

// invariant: expr holds at every clock edge outside reset
`define I420_ASSERT(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// same-cycle implication
`define I420_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define I420_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/i420tpg_pkg.sv
// Types and constants of the I420 test pattern generator
package i420tpg_pkg;

   localparam int CFG_DATA_W = 13;
   localparam int CSR_ADDR_W = 2;

   localparam logic [CSR_ADDR_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_FRAME_RATE   = 2'd2;

   localparam int RESET_WIDTH  = 640;
   localparam int RESET_HEIGHT = 480;
   localparam int RESET_RATE   = 30;
   localparam int RATE_DEFAULT = 30;

   localparam logic [1:0] PLANE_Y = 2'd0;
   localparam logic [1:0] PLANE_U = 2'd1;
   localparam logic [1:0] PLANE_V = 2'd2;

   localparam int LUMA_BG  = 128;
   localparam int LUMA_HI  = 235;
   localparam int LUMA_LO  = 16;
   localparam int BAR_MIN  = 4;
   localparam int BAR_DIV  = 10;
   localparam int U_BASE   = 96;
   localparam int V_BASE   = 176;
   localparam int U_PERIOD = 30;
   localparam int V_PERIOD = 45;

   // x / BAR_DIV equals (x * BAR_RECIP) >> BAR_SHIFT for x below 2**16
   localparam int BAR_RECIP = 52429;
   localparam int BAR_SHIFT = 19;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef struct packed {
      logic [7:0] sample_value;
      logic [1:0] plane;
      logic       last_of_frame;
   } rsp_item_type;

endpackage

// File: sv/i420_test_pattern_generator.sv
// I420 test pattern generator: one frame byte per byte request, luma then U then V
// (luma only for a frame one pixel wide or high). Each request item's byte lands in
// an output register backed by a one-entry skid stage, so items flow at one per
// clock while the result side keeps up. After reset and after every csr write a
// sequencer runs two divisions (bar step, bar position wrap) on a shared
// one-bit-per-cycle divider, and req_tready stays low until it completes.
`include "i420_test_pattern_generator_assert.svh"

module i420_test_pattern_generator #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096,
   parameter int MARK_SIZE  = 32,
   parameter int CELL_SIZE  = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,  // [0] byte_request
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [7:0]                         rsp_tdata,  // [7:0] sample_value
   output logic [1:0]                         rsp_tuser,  // [1:0] plane
   output logic                               rsp_tlast,
   input  logic                               csr_we,
   input  logic [i420tpg_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [i420tpg_pkg::CFG_DATA_W-1:0] csr_wdata
);
   import i420tpg_pkg::*;

   localparam int WB = $clog2(MAX_WIDTH + 1);
   localparam int PB = $clog2(MAX_WIDTH);
   localparam int HB = $clog2(MAX_HEIGHT + 1);
   localparam int RB = $clog2(MAX_HEIGHT);
   localparam int DW = (WB > 8) ? WB : 8;
   localparam int CB = (CELL_SIZE > 1) ? $clog2(CELL_SIZE) : 1;

   localparam logic [1:0] SEQ_IDLE = 2'd0;
   localparam logic [1:0] SEQ_STEP = 2'd1;
   localparam logic [1:0] SEQ_POS  = 2'd3;

   logic [CFG_DATA_W-1:0] width_ff, width_in;
   logic [CFG_DATA_W-1:0] height_ff, height_in;
   logic [7:0]            rate_ff, rate_in;
   logic [1:0]            seq_ff, seq_in;
   logic                  launch_ff, launch_in;
   logic [1:0]            plane_ff, plane_in;
   logic [PB-1:0]         col_ff, col_in;
   logic [RB-1:0]         row_ff, row_in;
   logic [CB-1:0]         ccell_ff, ccell_in;
   logic [CB-1:0]         rcell_ff, rcell_in;
   logic                  cpar_ff, cpar_in;
   logic                  rpar_ff, rpar_in;
   logic [PB-1:0]         bar_pos_ff, bar_pos_in;
   logic [PB-1:0]         bar_step_ff, bar_step_in;
   logic [WB-1:0]         bar_width_ff, bar_width_in;
   logic [4:0]            u_div_ff, u_div_in;
   logic [3:0]            u_off_ff, u_off_in;
   logic [5:0]            v_div_ff, v_div_in;
   logic [3:0]            v_off_ff, v_off_in;
   logic                  out_valid_ff, out_valid_in;
   logic                  skid_valid_ff, skid_valid_in;
   rsp_item_type          out_ff, out_in;
   rsp_item_type          skid_ff, skid_in;

   logic [WB-1:0]   eff_w;
   logic [HB-1:0]   eff_h;
   logic [7:0]      rate_eff;
   logic            chroma;
   logic [31:0]     mark;
   logic [WB-1:0]   col_lim;
   logic [HB-1:0]   row_lim;
   logic            col_wrap;
   logic            row_wrap;
   logic            frame_end;
   logic            busy;
   logic            item_go;
   logic            rsp_go;
   logic            capture;
   logic [WB:0]     bar_d;
   logic [WB:0]     pos_sum;
   logic [7:0]      luma;
   rsp_item_type    new_item;
   logic [DW-1:0]   div_dividend;
   logic [DW-1:0]   div_divisor;
   logic [DW-1:0]   div_quo;
   logic [DW-1:0]   div_rem;
   logic [DW-1:0]   step_raw;
   logic [WB+15:0]  bw_prod;
   logic [WB-1:0]   bw_quo;
   div_status_type  div_status;

   i420tpg_div #(.WIDTH(DW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (launch_ff),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .status    (div_status),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      if (width_ff == '0) begin
         eff_w = WB'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         eff_w = WB'(MAX_WIDTH);
      end else begin
         eff_w = WB'(width_ff);
      end
      if (height_ff == '0) begin
         eff_h = HB'(1);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         eff_h = HB'(MAX_HEIGHT);
      end else begin
         eff_h = HB'(height_ff);
      end
      rate_eff = (rate_ff == 8'd0) ? 8'(RATE_DEFAULT) : rate_ff;
      chroma   = (eff_w > WB'(1)) && (eff_h > HB'(1));
      mark     = 32'(MARK_SIZE);
      if (32'(eff_w) < mark) begin
         mark = 32'(eff_w);
      end
      if (32'(eff_h) < mark) begin
         mark = 32'(eff_h);
      end
   end

   // derivation sequencer
   assign busy    = (seq_ff != SEQ_IDLE);
   assign capture = div_status.done && !launch_ff;

   always_comb begin
      case (seq_ff)
         SEQ_STEP: begin
            div_dividend = DW'(eff_w);
            div_divisor  = DW'(rate_eff);
         end
         SEQ_POS: begin
            div_dividend = DW'(bar_pos_ff);
            div_divisor  = DW'(eff_w);
         end
         default: begin
            div_dividend = DW'(eff_w);
            div_divisor  = DW'(1);
         end
      endcase
      step_raw     = (div_quo == '0) ? DW'(1) : div_quo;
      bw_prod      = (WB + 16)'(eff_w) * (WB + 16)'(BAR_RECIP);
      bw_quo       = WB'(bw_prod >> BAR_SHIFT);
      bar_width_in = (bw_quo < WB'(BAR_MIN)) ? WB'(BAR_MIN) : bw_quo;
      bar_step_in  = bar_step_ff;
      seq_in       = seq_ff;
      launch_in    = 1'b0;
      if (csr_we) begin
         seq_in    = SEQ_STEP;
         launch_in = 1'b1;
      end else if (capture) begin
         case (seq_ff)
            SEQ_STEP: begin
               bar_step_in = (step_raw == DW'(eff_w)) ? '0 : PB'(step_raw);
               seq_in      = SEQ_POS;
               launch_in   = 1'b1;
            end
            default: begin
               seq_in = SEQ_IDLE;
            end
         endcase
      end
   end

   // pixel datapath
   assign req_tready = !busy && !skid_valid_ff;
   assign item_go    = req_tvalid && req_tready && req_tdata[0];
   assign rsp_go     = out_valid_ff && rsp_tready;

   always_comb begin
      col_lim = (plane_ff == PLANE_Y) ? eff_w : (eff_w >> 1);
      row_lim = (plane_ff == PLANE_Y) ? eff_h : (eff_h >> 1);
      col_wrap  = (WB'(col_ff) + WB'(1)) >= col_lim;
      row_wrap  = (HB'(row_ff) + HB'(1)) >= row_lim;
      frame_end = col_wrap && row_wrap &&
                  ((plane_ff == PLANE_V) || ((plane_ff == PLANE_Y) && !chroma));

      if ((WB + 1)'(col_ff) >= (WB + 1)'(bar_pos_ff)) begin
         bar_d = (WB + 1)'(col_ff) - (WB + 1)'(bar_pos_ff);
      end else begin
         bar_d = (WB + 1)'(col_ff) + (WB + 1)'(eff_w) - (WB + 1)'(bar_pos_ff);
      end
      if ((32'(row_ff) < mark) && (32'(col_ff) < mark)) begin
         luma = (rpar_ff ^ cpar_ff) ? 8'(LUMA_HI) : 8'(LUMA_LO);
      end else if (bar_d < (WB + 1)'(bar_width_ff)) begin
         luma = 8'(LUMA_HI);
      end else begin
         luma = 8'(LUMA_BG);
      end

      case (plane_ff)
         PLANE_Y: new_item.sample_value = luma;
         PLANE_U: new_item.sample_value = 8'(U_BASE) + 8'(u_off_ff);
         default: new_item.sample_value = 8'(V_BASE) + 8'(v_off_ff);
      endcase
      new_item.plane         = plane_ff;
      new_item.last_of_frame = frame_end;

      pos_sum = (WB + 1)'(bar_pos_ff) + (WB + 1)'(bar_step_ff);
      if (pos_sum >= (WB + 1)'(eff_w)) begin
         pos_sum = pos_sum - (WB + 1)'(eff_w);
      end

      width_in   = width_ff;
      height_in  = height_ff;
      rate_in    = rate_ff;
      plane_in   = plane_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      ccell_in   = ccell_ff;
      rcell_in   = rcell_ff;
      cpar_in    = cpar_ff;
      rpar_in    = rpar_ff;
      bar_pos_in = bar_pos_ff;
      u_div_in   = u_div_ff;
      u_off_in   = u_off_ff;
      v_div_in   = v_div_ff;
      v_off_in   = v_off_ff;

      if (csr_we) begin
         case (csr_addr)
            REG_FRAME_WIDTH:  width_in  = csr_wdata;
            REG_FRAME_HEIGHT: height_in = csr_wdata;
            REG_FRAME_RATE:   rate_in   = csr_wdata[7:0];
            default: ;
         endcase
         if ((csr_addr == REG_FRAME_WIDTH) || (csr_addr == REG_FRAME_HEIGHT) ||
             (csr_addr == REG_FRAME_RATE)) begin
            plane_in = PLANE_Y;
            col_in   = '0;
            row_in   = '0;
            ccell_in = '0;
            rcell_in = '0;
            cpar_in  = 1'b0;
            rpar_in  = 1'b0;
         end
      end else begin
         if (capture && (seq_ff == SEQ_POS)) begin
            bar_pos_in = PB'(div_rem);
         end
         if (item_go) begin
            if (col_wrap) begin
               col_in   = '0;
               ccell_in = '0;
               cpar_in  = 1'b0;
               if (row_wrap) begin
                  row_in   = '0;
                  rcell_in = '0;
                  rpar_in  = 1'b0;
               end else begin
                  row_in = row_ff + RB'(1);
                  if (rcell_ff == CB'(CELL_SIZE - 1)) begin
                     rcell_in = '0;
                     rpar_in  = ~rpar_ff;
                  end else begin
                     rcell_in = rcell_ff + CB'(1);
                  end
               end
            end else begin
               col_in = col_ff + PB'(1);
               if (ccell_ff == CB'(CELL_SIZE - 1)) begin
                  ccell_in = '0;
                  cpar_in  = ~cpar_ff;
               end else begin
                  ccell_in = ccell_ff + CB'(1);
               end
            end
            if (col_wrap && row_wrap) begin
               if (frame_end) begin
                  plane_in   = PLANE_Y;
                  bar_pos_in = PB'(pos_sum);
                  if (u_div_ff == 5'(U_PERIOD - 1)) begin
                     u_div_in = '0;
                     u_off_in = u_off_ff + 4'd1;
                  end else begin
                     u_div_in = u_div_ff + 5'd1;
                  end
                  if (v_div_ff == 6'(V_PERIOD - 1)) begin
                     v_div_in = '0;
                     v_off_in = v_off_ff + 4'd1;
                  end else begin
                     v_div_in = v_div_ff + 6'd1;
                  end
               end else if (plane_ff == PLANE_Y) begin
                  plane_in = PLANE_U;
               end else begin
                  plane_in = PLANE_V;
               end
            end
         end
      end
   end

   // output register and skid stage
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (rsp_go || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (item_go) begin
            out_in       = new_item;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (item_go) begin
         skid_in       = new_item;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= CFG_DATA_W'(RESET_WIDTH);
         height_ff     <= CFG_DATA_W'(RESET_HEIGHT);
         rate_ff       <= 8'(RESET_RATE);
         seq_ff        <= SEQ_STEP;
         launch_ff     <= 1'b1;
         plane_ff      <= PLANE_Y;
         col_ff        <= '0;
         row_ff        <= '0;
         ccell_ff      <= '0;
         rcell_ff      <= '0;
         cpar_ff       <= 1'b0;
         rpar_ff       <= 1'b0;
         bar_pos_ff    <= '0;
         u_div_ff      <= '0;
         u_off_ff      <= '0;
         v_div_ff      <= '0;
         v_off_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         width_ff      <= width_in;
         height_ff     <= height_in;
         rate_ff       <= rate_in;
         seq_ff        <= seq_in;
         launch_ff     <= launch_in;
         plane_ff      <= plane_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         ccell_ff      <= ccell_in;
         rcell_ff      <= rcell_in;
         cpar_ff       <= cpar_in;
         rpar_ff       <= rpar_in;
         bar_pos_ff    <= bar_pos_in;
         u_div_ff      <= u_div_in;
         u_off_ff      <= u_off_in;
         v_div_ff      <= v_div_in;
         v_off_ff      <= v_off_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bar_step_ff  <= bar_step_in;
      bar_width_ff <= bar_width_in;
      out_ff       <= out_in;
      skid_ff      <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.sample_value;
   assign rsp_tuser  = out_ff.plane;
   assign rsp_tlast  = out_ff.last_of_frame;

   `I420_ASSERT(a_skid_behind_out, !skid_valid_ff || out_valid_ff,
      "skid holds item while output empty")
   `I420_ASSERT_IMP(a_div_idle, seq_ff == SEQ_IDLE, !div_status.busy, "divider busy after derivation")
   `I420_ASSERT_IMP(a_pos_in_range, seq_ff == SEQ_IDLE,
      (WB'(col_ff) < col_lim) && (WB'(bar_pos_ff) < eff_w), "column or bar position out of range")
   `I420_ASSERT_NXT(a_frame_restart, item_go && frame_end,
      (plane_ff == PLANE_Y) && (col_ff == '0) && (row_ff == '0), "frame end did not restart frame")

endmodule

// File: sv/i420tpg_div.sv
// Restoring divider, one quotient bit per cycle
module i420tpg_div #(
   parameter int WIDTH = 14
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [WIDTH-1:0]            dividend,
   input  logic [WIDTH-1:0]            divisor,
   output i420tpg_pkg::div_status_type status,
   output logic [WIDTH-1:0]            quotient,
   output logic [WIDTH-1:0]            remainder
);
   import i420tpg_pkg::*;

   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] dsr_ff;
   logic [CW-1:0]    cnt_ff;
   logic             run_ff;
   logic             done_ff;
   logic [WIDTH:0]   shift;
   logic [WIDTH:0]   diff;

   always_comb begin
      shift  = {rem_ff, quo_ff[WIDTH-1]};
      diff   = shift - {1'b0, dsr_ff};
      rem_in = diff[WIDTH] ? shift[WIDTH-1:0] : diff[WIDTH-1:0];
      quo_in = {quo_ff[WIDTH-2:0], ~diff[WIDTH]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         run_ff  <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CW'(WIDTH);
      end else if (run_ff) begin
         cnt_ff  <= cnt_ff - CW'(1);
         run_ff  <= (cnt_ff != CW'(1));
         done_ff <= (cnt_ff == CW'(1));
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (run_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign status.busy = run_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;
   assign remainder   = rem_ff;

endmodule

// File: dv/tb_i420_test_pattern_generator.sv
// Testbench for the I420 test pattern generator: byte stream checked against a frame predictor
module tb_i420_test_pattern_generator;
   timeunit 1ns;
   timeprecision 1ps;

   import i420tpg_pkg::*;

   localparam int MAX_W        = 4096;
   localparam int MAX_H        = 4096;
   localparam int MARK         = 32;
   localparam int CELL         = 8;
   localparam int ITEM_TARGET  = 600;
   localparam int DRAIN_CYCLES = 8;
   localparam int LONG_HOLD    = 400;
   localparam int SETTLE_LIMIT = 2000;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;   // [0] byte_request
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;        // [7:0] sample_value
   logic [1:0]            rsp_tuser;        // [1:0] plane
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CFG_DATA_W-1:0] csr_wdata = '0;

   i420_test_pattern_generator #(
      .MAX_WIDTH (MAX_W),
      .MAX_HEIGHT(MAX_H),
      .MARK_SIZE (MARK),
      .CELL_SIZE (CELL)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   // frame generator state mirrored by the predictor
   logic [12:0] reg_width;
   logic [12:0] reg_height;
   logic [7:0]  reg_rate;
   logic [1:0]  pat_plane;
   logic [11:0] pat_col;
   logic [11:0] pat_row;
   logic [11:0] bar_pos;
   logic [11:0] bar_step;
   logic [4:0]  u_count;
   logic [3:0]  u_level;
   logic [5:0]  v_count;
   logic [3:0]  v_level;

   rsp_item_type expected_bytes[$];

   int errors;
   int n_requests;
   int n_frames;
   int n_writes;
   int send_idle_pct;
   int rsp_idle_pct;
   logic hold_start = 1'b0;
   int   hold_left  = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic int unsigned active_width();
      if (reg_width == 0) return 1;
      if (reg_width > MAX_W) return MAX_W;
      return reg_width;
   endfunction

   function automatic int unsigned active_height();
      if (reg_height == 0) return 1;
      if (reg_height > MAX_H) return MAX_H;
      return reg_height;
   endfunction

   function automatic void refresh_bar_step();
      int unsigned w;
      int unsigned r;
      int unsigned s;
      w = active_width();
      r = (reg_rate == 0) ? RATE_DEFAULT : reg_rate;
      s = w / r;
      if (s < 1) s = 1;
      bar_step = 12'(s % w);
      bar_pos  = 12'(bar_pos % w);
   endfunction

   function automatic void restart_frame();
      pat_plane = PLANE_Y;
      pat_col   = '0;
      pat_row   = '0;
   endfunction

   function automatic void pattern_reset();
      reg_width  = 13'(RESET_WIDTH);
      reg_height = 13'(RESET_HEIGHT);
      reg_rate   = 8'(RESET_RATE);
      restart_frame();
      bar_pos = '0;
      u_count = '0;
      u_level = '0;
      v_count = '0;
      v_level = '0;
      refresh_bar_step();
   endfunction

   function automatic int unsigned luma_value(int unsigned col, int unsigned row,
                                              int unsigned w, int unsigned h);
      int unsigned mark;
      int unsigned bar_w;
      int unsigned gap;
      mark = MARK;
      if (w < mark) mark = w;
      if (h < mark) mark = h;
      if (row < mark && col < mark)
         return (((row / CELL) + (col / CELL)) % 2 == 0) ? LUMA_LO : LUMA_HI;
      bar_w = w / BAR_DIV;
      if (bar_w < BAR_MIN) bar_w = BAR_MIN;
      gap = (col + w - bar_pos) % w;
      return (gap < bar_w) ? LUMA_HI : LUMA_BG;
   endfunction

   function automatic void finish_frame(int unsigned w);
      restart_frame();
      bar_pos = 12'((bar_pos + bar_step) % w);
      if (u_count + 1 >= U_PERIOD) begin
         u_count = '0;
         u_level = u_level + 1'b1;
      end else begin
         u_count = u_count + 1'b1;
      end
      if (v_count + 1 >= V_PERIOD) begin
         v_count = '0;
         v_level = v_level + 1'b1;
      end else begin
         v_count = v_count + 1'b1;
      end
   endfunction

   function automatic rsp_item_type next_pattern_byte();
      rsp_item_type b;
      int unsigned w;
      int unsigned h;
      int unsigned span_w;
      int unsigned span_h;
      w = active_width();
      h = active_height();
      b.plane = pat_plane;
      b.last_of_frame = 1'b0;
      if (pat_plane == PLANE_Y) begin
         b.sample_value = 8'(luma_value(pat_col, pat_row, w, h));
         span_w = w;
         span_h = h;
      end else begin
         b.sample_value = (pat_plane == PLANE_U) ? 8'(U_BASE + u_level) : 8'(V_BASE + v_level);
         span_w = w / 2;
         span_h = h / 2;
      end
      if (pat_col + 1 < span_w) begin
         pat_col = pat_col + 1'b1;
      end else begin
         pat_col = '0;
         if (pat_row + 1 < span_h) begin
            pat_row = pat_row + 1'b1;
         end else begin
            pat_row = '0;
            if (pat_plane == PLANE_Y && w / 2 != 0 && h / 2 != 0) begin
               pat_plane = PLANE_U;
            end else if (pat_plane == PLANE_U) begin
               pat_plane = PLANE_V;
            end else begin
               b.last_of_frame = 1'b1;
               finish_frame(w);
            end
         end
      end
      return b;
   endfunction

   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.sample_value  = rsp_tdata;
            got.plane         = rsp_tuser;
            got.last_of_frame = rsp_tlast;
            if (expected_bytes.size() == 0) begin
               $error("unexpected result: sample_value %0d plane %0d last_of_frame %0d",
                      got.sample_value, got.plane, got.last_of_frame);
               errors++;
            end else begin
               want = expected_bytes.pop_front();
               if (got.sample_value !== want.sample_value) begin
                  $error("sample_value: expected %0d, actual %0d",
                         want.sample_value, got.sample_value);
                  errors++;
               end
               if (got.plane !== want.plane) begin
                  $error("plane: expected %0d, actual %0d", want.plane, got.plane);
                  errors++;
               end
               if (got.last_of_frame !== want.last_of_frame) begin
                  $error("last_of_frame: expected %0d, actual %0d",
                         want.last_of_frame, got.last_of_frame);
                  errors++;
               end
               if (want.last_of_frame) n_frames++;
            end
         end
         if (req_tvalid && req_tready && req_tdata[0])
            expected_bytes.push_back(next_pattern_byte());
      end
   end

   always @(posedge clock) begin
      if (hold_start) hold_left <= LONG_HOLD;
      else if (hold_left != 0) hold_left <= hold_left - 1;
      rsp_tready <= !hold_start && hold_left == 0 && ($urandom_range(99) >= rsp_idle_pct);
   end

   task automatic send_request(input bit want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, want};
      do @(posedge clock); while (!req_tready);
      if (want) n_requests++;
   endtask

   task automatic send_batch(input int count, input int noise_pct);
      repeat (count) send_request($urandom_range(99) >= noise_pct);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_bytes.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] index,
                            input logic [CFG_DATA_W-1:0] value);
      while (!req_tready) @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         REG_FRAME_WIDTH:  reg_width  = value;
         REG_FRAME_HEIGHT: reg_height = value;
         REG_FRAME_RATE:   reg_rate   = value[7:0];
         default: ;
      endcase
      restart_frame();
      refresh_bar_step();
      n_writes++;
      repeat (2) @(posedge clock);
   endtask

   task automatic set_frame(input logic [12:0] w, input logic [12:0] h,
                            input logic [12:0] r);
      wait_idle();
      write_csr(REG_FRAME_WIDTH, w);
      write_csr(REG_FRAME_HEIGHT, h);
      write_csr(REG_FRAME_RATE, r);
   endtask

   function automatic logic [12:0] pick_dim();
      case ($urandom_range(9))
         0:       return 13'($urandom);
         1:       return 13'($urandom_range(17, 80));
         default: return 13'($urandom_range(1, 16));
      endcase
   endfunction

   task automatic test_reset_pattern();
      send_batch(6, 0);
   endtask

   task automatic test_register_extremes();
      set_frame(13'd0, 13'd0, 13'd0);
      send_batch(3, 0);
      send_request(1'b0);
      set_frame(13'h1FFF, 13'h1FFF, 13'd255);
      send_batch(3, 0);
   endtask

   task automatic test_frame_edges();
      // luma only, bar wider than the frame
      set_frame(13'd2, 13'd1, 13'd1);
      send_batch(2, 0);
      set_frame(13'd3, 13'd2, 13'd240);
      send_batch(8, 0);
   endtask

   task automatic test_backpressure();
      set_frame(13'd16, 13'd4, 13'd5);
      hold_start <= 1'b1;
      @(posedge clock);
      hold_start <= 1'b0;
      send_batch(40, 5);
      wait_idle();
      send_batch(30, 5);
   endtask

   task automatic test_chroma_steps();
      set_frame(13'd1, 13'd1, 13'd7);
      send_batch(100, 0);
   endtask

   task automatic test_random_phases();
      logic [12:0] rate;
      while (n_requests < ITEM_TARGET) begin
         if (n_requests < ITEM_TARGET / 3) begin
            send_idle_pct = 6;
            rsp_idle_pct  = 50;
         end else if (n_requests < 2 * ITEM_TARGET / 3) begin
            send_idle_pct = 50;
            rsp_idle_pct  = 6;
         end else begin
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
         end
         rate = ($urandom_range(3) == 0) ? 13'($urandom) : 13'($urandom_range(0, 255));
         set_frame(pick_dim(), pick_dim(), rate);
         send_batch($urandom_range(20, 70), 8);
      end
   endtask

   initial begin
      errors     = 0;
      n_requests = 0;
      n_frames   = 0;
      n_writes   = 0;
      send_idle_pct = 6;
      rsp_idle_pct  = 50;
      pattern_reset();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_reset_pattern();
      test_register_extremes();
      test_frame_edges();
      test_backpressure();
      test_chroma_steps();
      test_random_phases();

      req_tvalid <= 1'b0;
      fork
         while (expected_bytes.size() != 0) @(negedge clock);
         repeat (SETTLE_LIMIT) @(negedge clock);
      join_any
      disable fork;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_bytes.size() != 0) begin
         $error("%0d expected results never arrived", expected_bytes.size());
         errors++;
      end

      $display("Run covered %0d byte requests, %0d completed frames, %0d register writes,",
               n_requests, n_frames, n_writes);
      $display("including clamped sizes, luma-only frames, long output stalls and idle gaps.");
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: i420_test_pattern_generator.f
+incdir+sv
sv/i420tpg_pkg.sv
sv/i420tpg_div.sv
sv/i420_test_pattern_generator.sv
dv/tb_i420_test_pattern_generator.sv
